// ----- rtl/qmix_pkg.sv -----
// Shared types, constants and oscillator arithmetic for the quadrature mixer.
`timescale 1ns / 1ps

package qmix_pkg;

  // Oscillator word format: Q3.29 in 32 bits.
  localparam int OSC_BITS = 32;
  localparam int OSC_FRAC = 29;
  localparam int OSC_PROD_W = 2 * OSC_BITS;
  localparam int OSC_DIFF_W = OSC_PROD_W - OSC_FRAC + 1;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CH_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWICE_COS_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_START_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_START_2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS_START_1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COS_START_2    = 3'd6;

  // Mode register values.
  localparam logic MODE_MODULATE   = 1'b0;
  localparam logic MODE_DEMODULATE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [OSC_BITS-1:0] TWICE_COS_RESET = 32'h4000_0000;
  localparam logic [OSC_BITS-1:0] COS_START_RESET = 32'h2000_0000;
  localparam logic [CH_CNT_W-1:0] CH_CNT_RESET    = 6'd1;

  // Rounding constant for a right shift by OSC_FRAC.
  localparam logic signed [OSC_PROD_W-1:0] OSC_HALF = OSC_PROD_W'(1) << (OSC_FRAC - 1);
  localparam logic signed [OSC_DIFF_W-1:0] OSC_HI =
    OSC_DIFF_W'({1'b0, {(OSC_BITS-1){1'b1}}});
  localparam logic signed [OSC_DIFF_W-1:0] OSC_LO = -OSC_HI - OSC_DIFF_W'(1);

  // Classification of an item, made by the front end for the back end.
  typedef struct packed {
    logic restart;  // reload the oscillator histories first
    logic advance;  // first item of a time point: step the oscillator
  } cls_t;

  // Finish one oscillator step: round y1*k at bit 29, subtract y2, saturate to 32 bits.
  function automatic logic signed [OSC_BITS-1:0] osc_next_f(
    input logic signed [OSC_PROD_W-1:0] prod,
    input logic signed [OSC_BITS-1:0]   y2
  );
    logic signed [OSC_PROD_W-1:0] rnd;
    logic signed [OSC_DIFF_W-1:0] diff;
    logic signed [OSC_BITS-1:0]   res;
    rnd  = prod + OSC_HALF;
    diff = OSC_DIFF_W'(rnd >>> OSC_FRAC) - OSC_DIFF_W'(y2);
    if (diff > OSC_HI) begin
      res = OSC_BITS'(OSC_HI);
    end else if (diff < OSC_LO) begin
      res = OSC_BITS'(OSC_LO);
    end else begin
      res = OSC_BITS'(diff);
    end
    return res;
  endfunction

endpackage

// ----- rtl/qmix_front.sv -----
// Front end: accepts input transfers, tracks the channel position and classifies each item.
`timescale 1ns / 1ps

module qmix_front #(
  parameter int MAX_CHANNELS = 32,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [qmix_pkg::CH_CNT_W-1:0]     channel_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [3*SAMPLE_BITS-1:0]          in_samples_i,
  input  logic                              in_restart_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [3*SAMPLE_BITS-1:0]          push_samples_o,
  output qmix_pkg::cls_t                    push_cls_o
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > qmix_pkg::CH_CNT_W) ? CNT_W + 1 : qmix_pkg::CH_CNT_W + 1;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [CMP_W-1:0] cnt_raw, cnt_eff, pos_base, pos_inc;
  logic             xfer;

  assign in_ready_o     = push_ready_i;
  assign push_valid_o   = in_valid_i;
  assign push_samples_o = in_samples_i;
  assign xfer           = in_valid_i & push_ready_i;

  // Channel count, with zero taken as one and large values clamped to the channel limit.
  assign cnt_raw = CMP_W'(channel_count_i);
  always_comb begin
    if (cnt_raw == '0) begin
      cnt_eff = CMP_W'(1);
    end else if (cnt_raw > CMP_W'(MAX_CHANNELS)) begin
      cnt_eff = CMP_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cnt_raw;
    end
  end

  // A restart forces channel zero; channel zero steps the oscillator.
  assign pos_base           = in_restart_i ? '0 : CMP_W'(pos_q);
  assign pos_inc            = pos_base + CMP_W'(1);
  assign push_cls_o.restart = in_restart_i;
  assign push_cls_o.advance = (pos_base == '0);

  always_comb begin
    pos_d = pos_q;
    if (xfer) begin
      pos_d = (pos_inc >= cnt_eff) ? '0 : POS_W'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/qmix_queue.sv -----
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module qmix_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != 2'(DEPTH));
  assign pop_valid_o  = (fill_q != 2'd0);
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/qmix_back.sv -----
// Back end: steps the oscillator and mixes samples on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module qmix_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                mode_i,
  input  logic [qmix_pkg::OSC_BITS-1:0]       twice_cos_step_i,
  input  logic [qmix_pkg::OSC_BITS-1:0]       sin_start_1_i,
  input  logic [qmix_pkg::OSC_BITS-1:0]       sin_start_2_i,
  input  logic [qmix_pkg::OSC_BITS-1:0]       cos_start_1_i,
  input  logic [qmix_pkg::OSC_BITS-1:0]       cos_start_2_i,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  logic [3*SAMPLE_BITS-1:0]            pop_samples_i,
  input  qmix_pkg::cls_t                      pop_cls_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [SAMPLE_BITS-1:0]              signal_out_o,
  output logic [SAMPLE_BITS-1:0]              cos_part_out_o,
  output logic [SAMPLE_BITS-1:0]              sin_part_out_o,
  output logic                                saturated_o
);

  localparam int OB    = qmix_pkg::OSC_BITS;
  localparam int PW    = qmix_pkg::OSC_PROD_W;
  localparam int SUM_W = PW + 1;
  localparam int SW    = SAMPLE_BITS;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (qmix_pkg::OSC_FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OSC_S = 3'd1;
  localparam logic [2:0] ST_OSC_C = 3'd2;
  localparam logic [2:0] ST_MIX_S = 3'd3;
  localparam logic [2:0] ST_MIX_C = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  logic signed [OB-1:0] sin_a_q, sin_a_d, sin_b_q, sin_b_d;
  logic signed [OB-1:0] cos_a_q, cos_a_d, cos_b_q, cos_b_d;
  logic signed [OB-1:0] point_sin_q, point_sin_d, point_cos_q, point_cos_d;
  logic signed [OB-1:0] osc_new;

  logic signed [SW-1:0] sig_in_q, cos_in_q, sin_in_q;
  logic                 adv_q;

  logic signed [OB-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d, prod_q, p_sin_q;

  logic                 out_valid_q, out_valid_d;
  logic [SW-1:0]        sig_out_q, cos_out_q, sin_out_q;
  logic                 sat_q;
  logic [SW:0]          sig_res, cos_res, sin_res;
  logic signed [SUM_W-1:0] cos_rnd, sin_rnd, dem_rnd;
  logic                 load_out, pop;

  // Round-and-saturate of a Q29-scaled sum; the top bit reports clipping.
  function automatic logic [SW:0] clip_f(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    logic [SW:0]             res;
    sh = v >>> qmix_pkg::OSC_FRAC;
    if (sh > SAT_HI) begin
      res = {1'b1, SW'(SAT_HI)};
    end else if (sh < SAT_LO) begin
      res = {1'b1, SW'(SAT_LO)};
    end else begin
      res = {1'b0, SW'(sh)};
    end
    return res;
  endfunction

  assign pop         = (state_q == ST_IDLE) & pop_valid_i;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign load_out    = (state_q == ST_FIN) & (~out_valid_q | out_ready_i);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = sin_a_q;
    mul_b = twice_cos_step_i;
    unique case (state_q)
      ST_OSC_S: begin
        mul_a = sin_a_q;
      end
      ST_OSC_C: begin
        mul_a = cos_a_q;
      end
      ST_MIX_S: begin
        mul_a = point_sin_q;
        mul_b = (mode_i == qmix_pkg::MODE_DEMODULATE) ? OB'(sin_in_q) : OB'(sig_in_q);
      end
      ST_MIX_C: begin
        mul_a = point_cos_q;
        mul_b = (mode_i == qmix_pkg::MODE_DEMODULATE) ? OB'(cos_in_q) : OB'(sig_in_q);
      end
      default: begin
        mul_a = sin_a_q;
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  // Finish of an oscillator step; the history operand follows the current state.
  assign osc_new = qmix_pkg::osc_next_f(prod_q, (state_q == ST_OSC_C) ? sin_b_q : cos_b_q);

  // Sequencer and oscillator state.
  always_comb begin
    state_d     = state_q;
    sin_a_d     = sin_a_q;
    sin_b_d     = sin_b_q;
    cos_a_d     = cos_a_q;
    cos_b_d     = cos_b_q;
    point_sin_d = point_sin_q;
    point_cos_d = point_cos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (pop_cls_i.restart) begin
            sin_a_d = sin_start_1_i;
            sin_b_d = sin_start_2_i;
            cos_a_d = cos_start_1_i;
            cos_b_d = cos_start_2_i;
          end
          state_d = pop_cls_i.advance ? ST_OSC_S : ST_MIX_S;
        end
      end
      ST_OSC_S: begin
        state_d = ST_OSC_C;
      end
      ST_OSC_C: begin
        sin_b_d     = sin_a_q;
        sin_a_d     = osc_new;
        point_sin_d = osc_new;
        state_d     = ST_MIX_S;
      end
      ST_MIX_S: begin
        if (adv_q) begin
          cos_b_d     = cos_a_q;
          cos_a_d     = osc_new;
          point_cos_d = osc_new;
        end
        state_d = ST_MIX_C;
      end
      ST_MIX_C: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sin_a_q     <= '0;
      sin_b_q     <= '0;
      cos_a_q     <= qmix_pkg::COS_START_RESET;
      cos_b_q     <= qmix_pkg::COS_START_RESET;
      point_sin_q <= '0;
      point_cos_q <= '0;
    end else begin
      state_q     <= state_d;
      sin_a_q     <= sin_a_d;
      sin_b_q     <= sin_b_d;
      cos_a_q     <= cos_a_d;
      cos_b_q     <= cos_b_d;
      point_sin_q <= point_sin_d;
      point_cos_q <= point_cos_d;
    end
  end

  // Item payload, product register and the saved sine-side product. The product register
  // holds while a finished result waits, so the cosine-side product stays in place.
  always_ff @(posedge clk_i) begin
    if (state_q != ST_FIN) begin
      prod_q <= prod_d;
    end
    if (pop) begin
      sig_in_q <= pop_samples_i[SW-1:0];
      cos_in_q <= pop_samples_i[2*SW-1:SW];
      sin_in_q <= pop_samples_i[3*SW-1:2*SW];
      adv_q    <= pop_cls_i.advance;
    end
    if (state_q == ST_MIX_C) begin
      p_sin_q <= prod_q;
    end
  end

  // Result rounding and saturation; prod_q holds the cosine-side product here.
  assign cos_rnd = SUM_W'(prod_q) + HALF;
  assign sin_rnd = SUM_W'(p_sin_q) + HALF;
  assign dem_rnd = SUM_W'(prod_q) + SUM_W'(p_sin_q) + HALF;

  always_comb begin
    sig_res = '0;
    cos_res = '0;
    sin_res = '0;
    if (mode_i == qmix_pkg::MODE_DEMODULATE) begin
      sig_res = clip_f(dem_rnd);
    end else begin
      cos_res = clip_f(cos_rnd);
      sin_res = clip_f(sin_rnd);
    end
  end

  // Output register: holds a finished result until its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sig_out_q <= sig_res[SW-1:0];
      cos_out_q <= cos_res[SW-1:0];
      sin_out_q <= sin_res[SW-1:0];
      sat_q     <= sig_res[SW] | cos_res[SW] | sin_res[SW];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign signal_out_o   = sig_out_q;
  assign cos_part_out_o = cos_out_q;
  assign sin_part_out_o = sin_out_q;
  assign saturated_o    = sat_q;

endmodule

// ----- rtl/quadrature_mixer_recursive_osc.sv -----
// Top level of the multichannel quadrature mixer with a recursive sinusoid oscillator.
//
//   Port group   Dir  Contents
//   s_axis_*     in   tdata: signal_in, cos_part_in, sin_part_in; tuser: restart
//   m_axis_*     out  tdata: signal_out, cos_part_out, sin_part_out; tuser: saturated
//   cfg_*        in   register index and write data, taken when cfg_we_i is high
//
// The back end mixes each item in sine and cosine mixing states; on the first item of a time
// point the shared 32x32 multiplier first steps the sine and cosine recursions. It sets the
// rate. A two-entry queue lets the input keep taking transfers while the back end works or its
// output register waits on m_axis_tready. Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps

module quadrature_mixer_recursive_osc #(
  parameter int MAX_CHANNELS = 32,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [qmix_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qmix_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: signal_in, cos_part_in, sin_part_in, zero pad
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: restart
  input  logic                              s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: signal_out, cos_part_out, sin_part_out, zero pad
  output logic [((3*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: saturated
  output logic                              m_axis_tuser
);

  localparam int SW     = SAMPLE_BITS;
  localparam int SMP_W  = 3 * SW;
  localparam int DATA_W = ((SMP_W + 7) / 8) * 8;
  localparam int QW     = SMP_W + $bits(qmix_pkg::cls_t);
  localparam int OB     = qmix_pkg::OSC_BITS;

  // Configuration registers.
  logic                          mode_q;
  logic [qmix_pkg::CH_CNT_W-1:0] ch_cnt_q;
  logic [OB-1:0]                 twice_cos_q, sin_st1_q, sin_st2_q, cos_st1_q, cos_st2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= qmix_pkg::MODE_MODULATE;
      ch_cnt_q    <= qmix_pkg::CH_CNT_RESET;
      twice_cos_q <= qmix_pkg::TWICE_COS_RESET;
      sin_st1_q   <= '0;
      sin_st2_q   <= '0;
      cos_st1_q   <= qmix_pkg::COS_START_RESET;
      cos_st2_q   <= qmix_pkg::COS_START_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qmix_pkg::REG_MODE:           mode_q      <= cfg_data_i[0];
        qmix_pkg::REG_CHANNEL_COUNT:  ch_cnt_q    <= cfg_data_i[qmix_pkg::CH_CNT_W-1:0];
        qmix_pkg::REG_TWICE_COS_STEP: twice_cos_q <= cfg_data_i;
        qmix_pkg::REG_SIN_START_1:    sin_st1_q   <= cfg_data_i;
        qmix_pkg::REG_SIN_START_2:    sin_st2_q   <= cfg_data_i;
        qmix_pkg::REG_COS_START_1:    cos_st1_q   <= cfg_data_i;
        qmix_pkg::REG_COS_START_2:    cos_st2_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end to queue.
  logic                 push_valid, push_ready;
  logic [SMP_W-1:0]     push_samples;
  qmix_pkg::cls_t       push_cls;

  qmix_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (ch_cnt_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_samples_i    (s_axis_tdata[SMP_W-1:0]),
    .in_restart_i    (s_axis_tuser),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_samples_o  (push_samples),
    .push_cls_o      (push_cls)
  );

  // Queue to back end.
  logic                 pop_valid, pop_ready;
  logic [QW-1:0]        pop_data;
  qmix_pkg::cls_t       pop_cls;

  qmix_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_cls, push_samples}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_cls = qmix_pkg::cls_t'(pop_data[QW-1:SMP_W]);

  // Back end and output packing.
  logic [SW-1:0] sig_out, cos_out, sin_out;

  qmix_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .twice_cos_step_i (twice_cos_q),
    .sin_start_1_i    (sin_st1_q),
    .sin_start_2_i    (sin_st2_q),
    .cos_start_1_i    (cos_st1_q),
    .cos_start_2_i    (cos_st2_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_samples_i    (pop_data[SMP_W-1:0]),
    .pop_cls_i        (pop_cls),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .signal_out_o     (sig_out),
    .cos_part_out_o   (cos_out),
    .sin_part_out_o   (sin_out),
    .saturated_o      (m_axis_tuser)
  );

  assign m_axis_tdata = DATA_W'({sin_out, cos_out, sig_out});

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the quadrature mixer with recursive oscillator.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_CHANNELS = 32;
  localparam int DATA_W       = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1950;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int OSC_BITS     = qmix_pkg::OSC_BITS;
  localparam int OSC_FRAC     = qmix_pkg::OSC_FRAC;
  localparam int CFG_IDX_W    = qmix_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = qmix_pkg::CFG_DATA_W;
  localparam int CH_CNT_W     = qmix_pkg::CH_CNT_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OSC_BITS-1:0]    osc_word_t;

  localparam sample_t   SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t   SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam osc_word_t OSC_MAX    = {1'b0, {(OSC_BITS-1){1'b1}}};
  localparam osc_word_t OSC_MIN    = {1'b1, {(OSC_BITS-1){1'b0}}};
  localparam longint    ROUND_HALF = longint'(1) << (OSC_FRAC - 1);

  // One expected output transfer.
  typedef struct packed {
    logic    saturated;
    sample_t sin_part;
    sample_t cos_part;
    sample_t signal;
  } mix_out_t;

  // Shadow of the mixer: its own registers, oscillator state and the queue of expected outputs.
  class mixer_scoreboard;
    logic                demod;
    logic [CH_CNT_W-1:0] ch_count;
    osc_word_t           step_coef;
    osc_word_t           sin_init_1, sin_init_2, cos_init_1, cos_init_2;
    osc_word_t           sin_y1, sin_y2, cos_y1, cos_y2, cur_sin, cur_cos;
    int unsigned         ch_pos;
    int unsigned         n_errors;
    mix_out_t            mix_results_q[$];

    function new();
      demod      = qmix_pkg::MODE_MODULATE;
      ch_count   = qmix_pkg::CH_CNT_RESET;
      step_coef  = qmix_pkg::TWICE_COS_RESET;
      sin_init_1 = '0;
      sin_init_2 = '0;
      cos_init_1 = qmix_pkg::COS_START_RESET;
      cos_init_2 = qmix_pkg::COS_START_RESET;
      sin_y1     = '0;
      sin_y2     = '0;
      cos_y1     = qmix_pkg::COS_START_RESET;
      cos_y2     = qmix_pkg::COS_START_RESET;
      cur_sin    = '0;
      cur_cos    = '0;
      ch_pos     = 0;
      n_errors   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      unique case (idx)
        qmix_pkg::REG_MODE:           demod = val[0];
        qmix_pkg::REG_CHANNEL_COUNT:  ch_count = val[CH_CNT_W-1:0];
        qmix_pkg::REG_TWICE_COS_STEP: step_coef = val;
        qmix_pkg::REG_SIN_START_1:    sin_init_1 = val;
        qmix_pkg::REG_SIN_START_2:    sin_init_2 = val;
        qmix_pkg::REG_COS_START_1:    cos_init_1 = val;
        qmix_pkg::REG_COS_START_2:    cos_init_2 = val;
        default: ;
      endcase
    endfunction

    // One recursion step: round y1*k at the binary point, subtract y2, clip to the word.
    function osc_word_t osc_advance(input osc_word_t y1, input osc_word_t y2);
      longint acc;
      acc = ((longint'(y1) * longint'(step_coef) + ROUND_HALF) >>> OSC_FRAC) - longint'(y2);
      if (acc > longint'(OSC_MAX)) return OSC_MAX;
      if (acc < longint'(OSC_MIN)) return OSC_MIN;
      return osc_word_t'(acc);
    endfunction

    function sample_t clip_sample(input longint v, inout logic flag);
      if (v > longint'(SAMPLE_MAX)) begin
        flag = 1'b1;
        return SAMPLE_MAX;
      end
      if (v < longint'(SAMPLE_MIN)) begin
        flag = 1'b1;
        return SAMPLE_MIN;
      end
      return sample_t'(v);
    endfunction

    // Predict the output for an accepted input transfer.
    function void note_sample(input sample_t sig, input sample_t cos_in, input sample_t sin_in,
                              input logic restart);
      mix_out_t    want;
      int unsigned count;
      osc_word_t   next_sin, next_cos;
      logic        flag;
      count = (ch_count == 0) ? 1 : ((ch_count > MAX_CHANNELS) ? MAX_CHANNELS : ch_count);
      if (restart) begin
        sin_y1 = sin_init_1;
        sin_y2 = sin_init_2;
        cos_y1 = cos_init_1;
        cos_y2 = cos_init_2;
        ch_pos = 0;
      end
      // The oscillator steps on the first sample of each time point.
      if (ch_pos == 0) begin
        next_sin = osc_advance(sin_y1, sin_y2);
        next_cos = osc_advance(cos_y1, cos_y2);
        sin_y2   = sin_y1;
        sin_y1   = next_sin;
        cos_y2   = cos_y1;
        cos_y1   = next_cos;
        cur_sin  = next_sin;
        cur_cos  = next_cos;
      end
      flag = 1'b0;
      want = '0;
      if (demod == qmix_pkg::MODE_MODULATE) begin
        want.cos_part = clip_sample(
          (longint'(sig) * longint'(cur_cos) + ROUND_HALF) >>> OSC_FRAC, flag);
        want.sin_part = clip_sample(
          (longint'(sig) * longint'(cur_sin) + ROUND_HALF) >>> OSC_FRAC, flag);
      end else begin
        want.signal = clip_sample((longint'(cos_in) * longint'(cur_cos) +
                                   longint'(sin_in) * longint'(cur_sin) + ROUND_HALF) >>> OSC_FRAC,
                                  flag);
      end
      want.saturated = flag;
      ch_pos++;
      if (ch_pos >= count) ch_pos = 0;
      mix_results_q.push_back(want);
    endfunction

    // Compare an output transfer with the oldest expectation.
    function void check_result(input logic [DATA_W-1:0] data, input logic user);
      mix_out_t got, want;
      got.signal    = data[SAMPLE_BITS-1:0];
      got.cos_part  = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      got.sin_part  = data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      got.saturated = user;
      if (mix_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
          $display("mismatch: output with none expected: signal %0d cos %0d sin %0d sat %0b",
                   got.signal, got.cos_part, got.sin_part, got.saturated);
        end
        return;
      end
      want = mix_results_q.pop_front();
      if (got.signal !== want.signal || got.cos_part !== want.cos_part ||
          got.sin_part !== want.sin_part || got.saturated !== want.saturated) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
          $display("mismatch: expected signal %0d cos %0d sin %0d sat %0b",
                   want.signal, want.cos_part, want.sin_part, want.saturated);
          $display("          actual   signal %0d cos %0d sin %0d sat %0b",
                   got.signal, got.cos_part, got.sin_part, got.saturated);
        end
      end
    endfunction

    function int unsigned pending();
      return mix_results_q.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata from bit 0: signal_in, cos_part_in, sin_part_in
  logic [DATA_W-1:0]     s_axis_tdata  = '0;
  // tuser: restart
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata from bit 0: signal_out, cos_part_out, sin_part_out
  logic [DATA_W-1:0]     m_axis_tdata;
  // tuser: saturated
  logic                  m_axis_tuser;

  mixer_scoreboard mix_sb;
  bit              tx_idle_on   = 1'b1;
  bit              rx_stall_on  = 1'b1;
  int unsigned     items_sent   = 0;
  int unsigned     ready_hold   = 0;
  int unsigned     quiet_cycles = 0;

  quadrature_mixer_recursive_osc #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_MAX;
        1:       return SAMPLE_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 35) return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
    return sample_t'($urandom());
  endfunction

  function automatic logic [CFG_DATA_W-1:0] to_q3_29(input real v);
    return CFG_DATA_W'($rtoi(v * 536870912.0));
  endfunction

  // Register words for a sinusoid of the given step angle and amplitude, as software sets them.
  function automatic void osc_words(input real theta, input real amp,
                                    output logic [CFG_DATA_W-1:0] k, s1, s2, c1, c2);
    k  = to_q3_29(2.0 * $cos(theta));
    s1 = to_q3_29(-amp * $sin(theta));
    s2 = to_q3_29(-amp * $sin(2.0 * theta));
    c1 = to_q3_29(amp * $cos(theta));
    c2 = to_q3_29(amp * $cos(2.0 * theta));
  endfunction

  function automatic void pick_oscillator(output logic [CFG_DATA_W-1:0] k, s1, s2, c1, c2);
    real theta, amp;
    if ($urandom_range(0, 4) == 0) begin
      // Arbitrary words: the recursion may run away and clip.
      k  = $urandom();
      s1 = $urandom();
      s2 = $urandom();
      c1 = $urandom();
      c2 = $urandom();
    end else begin
      theta = $urandom_range(1, 10000) * 3.14159265358979 / 10001.0;
      amp   = $urandom_range(250, 3900) / 1000.0;
      osc_words(theta, amp, k, s1, s2, c1, c2);
    end
  endfunction

  // Drive one input item and wait for its transfer.
  task automatic send_sample(input sample_t sig, input sample_t cos_in, input sample_t sin_in,
                             input logic restart);
    int unsigned gap;
    gap = tx_idle_on ? gap_cycles() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sin_in, cos_in, sig};
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    mix_sb.note_sample(sig, cos_in, sin_in, restart);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    mix_sb.write_reg(idx, val);
  endtask

  // Drain the mixer, then write every register.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] mode_word, count_word,
                               input logic [CFG_DATA_W-1:0] k, s1, s2, c1, c2);
    s_axis_tvalid <= 1'b0;
    while (mix_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(qmix_pkg::REG_MODE, mode_word);
    write_reg(qmix_pkg::REG_CHANNEL_COUNT, count_word);
    write_reg(qmix_pkg::REG_TWICE_COS_STEP, k);
    write_reg(qmix_pkg::REG_SIN_START_1, s1);
    write_reg(qmix_pkg::REG_SIN_START_2, s2);
    write_reg(qmix_pkg::REG_COS_START_1, c1);
    write_reg(qmix_pkg::REG_COS_START_2, c2);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: ready with random stalls.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!rx_stall_on || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= rx_stall_on ? $urandom_range(0, 6) : 0;
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold    <= gap_cycles();
    end
  end

  // Check every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mix_sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] k, s1, s2, c1, c2, count_word;
    int unsigned           first_random, rec_left, phase_len, pick;
    logic                  restart, first_restart;
    mix_sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: cosine stays at one and sine at zero, so samples pass through.
    send_sample(SAMPLE_MAX, '0, '0, 1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_sample('0, '1, '1, 1'b1);
    send_sample('1, '0, '0, 1'b0);
    send_sample(sample_t'(1), '0, '0, 1'b0);

    // Upper mode bits are ignored and a zero channel count acts as one. The new start words
    // wait for the restart on the third sample.
    osc_words(0.6, 3.9, k, s1, s2, c1, c2);
    load_settings(32'hFFFF_FFFE, 32'd0, k, s1, s2, c1, c2);
    send_sample(SAMPLE_MAX, '0, '0, 1'b0);
    send_sample(SAMPLE_MIN, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX, '0, '0, 1'b1);
    send_sample(SAMPLE_MIN, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX, '0, '0, 1'b0);

    // Demodulate with a channel count above the maximum; a restart in mid point steps at once.
    load_settings(32'h0000_0001, 32'd63, k, s1, s2, c1, c2);
    send_sample('0, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_sample('0, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample('0, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_sample('0, '0, '0, 1'b0);
    send_sample('0, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_sample('0, '1, '1, 1'b0);

    // Extreme oscillator words drive the recursion into its own clipping.
    load_settings(32'h0000_0001, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF);
    send_sample('0, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_sample('0, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_sample('0, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_sample('0, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample('0, sample_t'(1), '1, 1'b0);

    // Random phases: new settings each time, then records that mostly begin with a restart.
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        count_word = 32'd0;
      end else if (pick == 1) begin
        count_word = $urandom_range(33, 63);
      end else if (pick < 5) begin
        count_word = $urandom_range(9, 32);
      end else begin
        count_word = $urandom_range(1, 8);
      end
      count_word[CFG_DATA_W-1:CH_CNT_W] = (CFG_DATA_W - CH_CNT_W)'($urandom());
      pick_oscillator(k, s1, s2, c1, c2);
      load_settings({31'($urandom()), 1'($urandom_range(0, 1))}, count_word,
                    k, s1, s2, c1, c2);
      tx_idle_on    = ($urandom_range(0, 3) != 0);
      rx_stall_on   = ($urandom_range(0, 3) != 0);
      phase_len     = $urandom_range(20, 250);
      first_restart = ($urandom_range(0, 9) != 0);
      rec_left      = $urandom_range(1, 120);
      for (int i = 0; i < phase_len && items_sent - first_random < RANDOM_ITEMS; i++) begin
        if (i == 0) begin
          restart = first_restart;
        end else begin
          restart = (rec_left == 0) || ($urandom_range(0, 49) == 0);
        end
        if (restart) rec_left = $urandom_range(1, 120);
        rec_left--;
        send_sample(rand_sample(), rand_sample(), rand_sample(), restart);
      end
    end

    // Wait for the last outputs, then give any stray transfer time to show up.
    s_axis_tvalid <= 1'b0;
    while (mix_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mix_sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
